FILE: rtl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [6:0] DEV_ADDR_RST = 7'd80;

    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [9:0] {
        PH_IDLE    = 10'b00_0000_0001,
        PH_START   = 10'b00_0000_0010,
        PH_DEVW    = 10'b00_0000_0100,
        PH_PSTOP   = 10'b00_0000_1000,
        PH_MADDR   = 10'b00_0001_0000,
        PH_RESTART = 10'b00_0010_0000,
        PH_DEVR    = 10'b00_0100_0000,
        PH_RDATA   = 10'b00_1000_0000,
        PH_WDATA   = 10'b01_0000_0000,
        PH_STOP    = 10'b10_0000_0000
    } t_phase;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] mem_addr;
        logic [7:0] byte_count;
        logic [7:0] wr_data;
        logic       sda_in;
    } t_item;

    typedef struct packed {
        logic       scl_level;
        logic       sda_release;
        logic       busy_res;
        logic       rd_valid;
        logic [7:0] rd_data;
        logic       rd_last;
        logic       byte_taken;
        logic       done_res;
    } t_result;

endpackage

FILE: rtl/i2c_eeprom_master_unit.sv
`timescale 1ns / 1ps
// i2c eeprom master, random read and byte write, one bus half-period per item
//
// each input transfer is one tick: tuser carries the command (tick, read,
// write), tdata the memory address, byte count, write byte and sampled sda.
// each accepted item yields exactly one output transfer giving the scl level
// and sda drive for that tick plus busy, read byte, byte taken and done flags;
// tlast marks the final byte of a read.
// the device address register is written through i_cfg_we / i_cfg_wdata; the user
// writes it only while the block is idle, the block does not enforce it; it resets to 80.
//
// an item is held in the input register while the sequencer step is computed
// from it, and the result is registered in the output register once that
// register is free. throughput is one item per cycle while the receiver takes
// results, bounded only by the single sequencer step between the two
// registers.
// reset (synchronous, active low) clears both stages and returns the sequencer
// to idle with the bus released. when the receiver stalls, the result is held,
// the input register fills and tready drops; nothing is lost.

module i2c_eeprom_master_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [6:0]                        i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // mem_addr[7:0], byte_count[15:8], wr_data[23:16], sda_in[24], zeros above
    input  logic [i2cm_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // cmd[1:0]
    input  logic [i2cm_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // scl_level[0], sda_release[1], busy_res[2], rd_valid[3], rd_data[11:4],
    // byte_taken[12], done_res[13], zeros above
    output logic [i2cm_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    output logic                              o_m_axis_tlast
);

    logic [6:0]        r_dev;
    logic              r_in_valid;
    i2cm_pkg::t_item   r_in;
    logic              r_out_valid;
    i2cm_pkg::t_result r_out;
    i2cm_pkg::t_result w_res;
    logic              w_adv;
    logic              w_in_xfer;

    assign w_adv           = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= i2cm_pkg::DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in.cmd        <= i_s_axis_tuser[1:0];
            r_in.mem_addr   <= i_s_axis_tdata[7:0];
            r_in.byte_count <= i_s_axis_tdata[15:8];
            r_in.wr_data    <= i_s_axis_tdata[23:16];
            r_in.sda_in     <= i_s_axis_tdata[24];
        end
    end

    i2cm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_adv),
        .i_item     (r_in),
        .i_dev_addr (r_dev),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tlast  = r_out.rd_last;
    assign o_m_axis_tdata  = {2'b00,
                              r_out.done_res, r_out.byte_taken, r_out.rd_data,
                              r_out.rd_valid, r_out.busy_res, r_out.sda_release,
                              r_out.scl_level};

endmodule

FILE: rtl/i2cm_seq.sv
`timescale 1ns / 1ps

module i2cm_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2cm_pkg::t_item   i_item,
    input  logic [6:0]        i_dev_addr,
    output i2cm_pkg::t_result o_res
);

    i2cm_pkg::t_phase r_phase, n_phase;
    logic [3:0] r_bit_idx, n_bit_idx;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] r_cur_addr, n_cur_addr;
    logic       r_is_write, n_is_write;
    logic [1:0] r_tick, n_tick;

    // effective state after a possible request on this tick
    i2cm_pkg::t_phase w_ph;
    logic [1:0] w_tick;
    logic [3:0] w_bidx;
    logic [7:0] w_shift;
    logic       w_req;
    logic       w_lvl;
    logic       w_last;
    logic [7:0] w_rd_shift;

    always_comb begin
        w_req = (r_phase == i2cm_pkg::PH_IDLE)
             && ((i_item.cmd == i2cm_pkg::CMD_READ)
              || ((i_item.cmd == i2cm_pkg::CMD_WRITE) && (i_item.byte_count != 8'd0)));
        w_ph   = w_req ? i2cm_pkg::PH_START : r_phase;
        w_tick = w_req ? 2'd1 : r_tick;
        w_bidx = w_req ? 4'd0 : r_bit_idx;
        // write data is latched at the head of each data byte
        w_shift = ((r_phase == i2cm_pkg::PH_WDATA) && (r_bit_idx == 4'd0) && (r_tick == 2'd0))
                ? i_item.wr_data : r_shift;
        w_lvl      = w_bidx[3] ? 1'b1 : w_shift[7];
        w_last     = (r_bytes_left <= 8'd1);
        w_rd_shift = {r_shift[6:0], i_item.sda_in};
    end

    always_comb begin
        n_phase      = w_ph;
        n_tick       = w_tick;
        n_bit_idx    = w_bidx;
        n_shift      = w_shift;
        n_bytes_left = r_bytes_left;
        n_cur_addr   = r_cur_addr;
        n_is_write   = r_is_write;
        o_res        = '0;
        o_res.scl_level   = 1'b1;
        o_res.sda_release = 1'b1;

        if (w_req) begin
            n_is_write   = (i_item.cmd == i2cm_pkg::CMD_WRITE);
            n_cur_addr   = i_item.mem_addr;
            n_bytes_left = (i_item.byte_count != 8'd0) ? i_item.byte_count : 8'd1;
        end

        unique case (w_ph)
            i2cm_pkg::PH_IDLE: begin
            end
            i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
                o_res.busy_res = 1'b1;
                if (w_tick == 2'd0) begin
                    o_res.scl_level = 1'b0;
                    n_tick = 2'd1;
                end else if (w_tick == 2'd1) begin
                    n_tick = 2'd2;
                end else begin
                    o_res.sda_release = 1'b0;
                    n_bit_idx = 4'd0;
                    n_tick    = 2'd0;
                    if (w_ph == i2cm_pkg::PH_RESTART) begin
                        n_phase = i2cm_pkg::PH_DEVR;
                        n_shift = {i_dev_addr, 1'b1};
                    end else begin
                        n_phase = i2cm_pkg::PH_DEVW;
                        n_shift = {i_dev_addr, 1'b0};
                    end
                end
            end
            i2cm_pkg::PH_DEVW, i2cm_pkg::PH_MADDR, i2cm_pkg::PH_DEVR,
            i2cm_pkg::PH_WDATA: begin
                o_res.busy_res    = 1'b1;
                o_res.scl_level   = (w_tick != 2'd0);
                o_res.sda_release = w_lvl;
                o_res.byte_taken  = (w_ph == i2cm_pkg::PH_WDATA)
                                 && (w_bidx == 4'd0) && (w_tick == 2'd0);
                if (w_tick == 2'd0) begin
                    n_tick = 2'd1;
                end else begin
                    n_tick = 2'd0;
                    if (!w_bidx[3]) begin
                        n_shift   = {w_shift[6:0], 1'b0};
                        n_bit_idx = w_bidx + 4'd1;
                    end else begin
                        // ack slot finished
                        n_bit_idx = 4'd0;
                        case (w_ph)
                            i2cm_pkg::PH_DEVW: begin
                                if (!i_item.sda_in) begin
                                    n_phase = i2cm_pkg::PH_MADDR;
                                    n_shift = r_cur_addr;
                                end else begin
                                    n_phase = i2cm_pkg::PH_PSTOP;
                                end
                            end
                            i2cm_pkg::PH_MADDR: begin
                                if (r_is_write) begin
                                    n_phase = i2cm_pkg::PH_WDATA;
                                    n_shift = 8'd0;
                                end else begin
                                    n_phase = i2cm_pkg::PH_RESTART;
                                end
                            end
                            i2cm_pkg::PH_DEVR: begin
                                n_phase = i2cm_pkg::PH_RDATA;
                                n_shift = 8'd0;
                            end
                            default: begin
                                n_phase = i2cm_pkg::PH_STOP;
                            end
                        endcase
                    end
                end
            end
            i2cm_pkg::PH_RDATA: begin
                o_res.busy_res = 1'b1;
                if (!w_bidx[3]) begin
                    if (w_tick == 2'd0) begin
                        o_res.scl_level = 1'b0;
                        n_tick = 2'd1;
                    end else begin
                        n_tick    = 2'd0;
                        n_shift   = w_rd_shift;
                        n_bit_idx = w_bidx + 4'd1;
                        if (w_bidx == 4'd7) begin
                            o_res.rd_valid = 1'b1;
                            o_res.rd_data  = w_rd_shift;
                            o_res.rd_last  = w_last;
                        end
                    end
                end else begin
                    // ack all but the last byte
                    o_res.sda_release = w_last;
                    if (w_tick == 2'd0) begin
                        o_res.scl_level = 1'b0;
                        n_tick = 2'd1;
                    end else begin
                        n_tick    = 2'd0;
                        n_bit_idx = 4'd0;
                        if (w_last) begin
                            n_phase = i2cm_pkg::PH_STOP;
                        end else begin
                            n_bytes_left = r_bytes_left - 8'd1;
                            n_shift      = 8'd0;
                        end
                    end
                end
            end
            i2cm_pkg::PH_PSTOP, i2cm_pkg::PH_STOP: begin
                o_res.busy_res = 1'b1;
                if (w_tick == 2'd0) begin
                    o_res.scl_level   = 1'b0;
                    o_res.sda_release = 1'b0;
                    n_tick = 2'd1;
                end else if (w_tick == 2'd1) begin
                    o_res.sda_release = 1'b0;
                    n_tick = 2'd2;
                end else begin
                    n_tick    = 2'd1;
                    n_bit_idx = 4'd0;
                    if (w_ph == i2cm_pkg::PH_PSTOP) begin
                        n_phase = i2cm_pkg::PH_START;
                    end else if (r_is_write && (r_bytes_left > 8'd1)) begin
                        n_bytes_left = r_bytes_left - 8'd1;
                        n_cur_addr   = r_cur_addr + 8'd1;
                        n_phase      = i2cm_pkg::PH_START;
                    end else begin
                        n_bytes_left = 8'd0;
                        if (r_is_write) begin
                            n_cur_addr = r_cur_addr + 8'd1;
                        end
                        o_res.done_res = 1'b1;
                        n_phase = i2cm_pkg::PH_IDLE;
                        n_tick  = 2'd0;
                    end
                end
            end
            default: begin
                n_phase   = i2cm_pkg::PH_IDLE;
                n_tick    = 2'd0;
                n_bit_idx = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::PH_IDLE;
            r_bit_idx    <= 4'd0;
            r_shift      <= 8'd0;
            r_bytes_left <= 8'd0;
            r_cur_addr   <= 8'd0;
            r_is_write   <= 1'b0;
            r_tick       <= 2'd0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_idx    <= n_bit_idx;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_cur_addr   <= n_cur_addr;
            r_is_write   <= n_is_write;
            r_tick       <= n_tick;
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.done_res) |=> (r_phase == i2cm_pkg::PH_IDLE))
        else $error("stop finished but sequencer not idle");

    a_rd_full_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.rd_valid) |=> (r_bit_idx == 4'd8 && r_tick == 2'd0))
        else $error("read byte reported before eight bits");

    a_take_at_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.byte_taken) |=> (r_tick == 2'd1 && r_bit_idx == 4'd0
                                          && r_phase == i2cm_pkg::PH_WDATA))
        else $error("write byte taken away from byte head");

    a_bit_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bit_idx <= 4'd8) && (r_tick != 2'd3))
        else $error("bit counter out of range");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // command code that the block has to ignore
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [6:0]                       cfg_wdata = '0;
    logic                             s_tvalid = 1'b0;
    logic [i2cm_pkg::IN_DATA_W-1:0]   s_tdata = '0;
    logic [i2cm_pkg::IN_USER_W-1:0]   s_tuser = i2cm_pkg::CMD_TICK;
    logic                             m_tready = 1'b0;
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    logic [i2cm_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic                             o_m_axis_tlast;

    i2c_eeprom_master_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    i2cm_pkg::t_item   pending_ticks[$];
    i2cm_pkg::t_result expected_bus[$];
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    logic        in_fired = 1'b0;
    logic        out_fired = 1'b0;
    logic        tx_calm = 1'b0;
    logic        rx_calm = 1'b0;
    int unsigned tx_wait = 0;
    int unsigned rx_wait = 0;

    // sequencer state of the predicted master
    i2cm_pkg::t_phase bus_phase = i2cm_pkg::PH_IDLE;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  bytes_rem = '0;
    logic [7:0]  word_addr = '0;
    logic        writing = 1'b0;
    logic [1:0]  half = '0;
    logic [6:0]  dev_addr = i2cm_pkg::DEV_ADDR_RST;

    task automatic load_byte(input i2cm_pkg::t_phase ph, input logic [7:0] b);
        bus_phase = ph;
        shreg = b;
        bit_cnt = '0;
        half = '0;
    endtask

    // one half period of a sent byte or of its ack slot
    task automatic shift_out(input logic sda, output logic scl, output logic rel,
                             output logic fin, output logic ack);
        rel = (bit_cnt < 8) ? shreg[7] : 1'b1;
        scl = (half != 0);
        fin = 1'b0;
        ack = 1'b0;
        if (half == 0) begin
            half = 1;
        end else begin
            half = 0;
            if (bit_cnt < 8) begin
                shreg = shreg << 1;
                bit_cnt++;
            end else begin
                ack = (sda == 1'b0);
                bit_cnt = '0;
                fin = 1'b1;
            end
        end
    endtask

    task automatic eeprom_master_step(input i2cm_pkg::t_item it,
                                      output i2cm_pkg::t_result r);
        logic scl;
        logic rel;
        logic fin;
        logic ack;
        logic last;
        r = '0;
        r.scl_level = 1'b1;
        r.sda_release = 1'b1;
        if (bus_phase == i2cm_pkg::PH_IDLE && (it.cmd == i2cm_pkg::CMD_READ ||
                (it.cmd == i2cm_pkg::CMD_WRITE && it.byte_count != 0))) begin
            writing = (it.cmd == i2cm_pkg::CMD_WRITE);
            word_addr = it.mem_addr;
            bytes_rem = (it.byte_count != 0) ? it.byte_count : 8'd1;
            bus_phase = i2cm_pkg::PH_START;
            half = 1;
            bit_cnt = '0;
        end
        r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
        case (bus_phase)
            i2cm_pkg::PH_START, i2cm_pkg::PH_RESTART: begin
                r.scl_level = (half != 0);
                r.sda_release = (half != 2);
                if (half != 2) begin
                    half++;
                end else if (bus_phase == i2cm_pkg::PH_RESTART) begin
                    load_byte(i2cm_pkg::PH_DEVR, {dev_addr, 1'b1});
                end else begin
                    load_byte(i2cm_pkg::PH_DEVW, {dev_addr, 1'b0});
                end
            end
            i2cm_pkg::PH_DEVW: begin
                shift_out(it.sda_in, scl, rel, fin, ack);
                r.scl_level = scl;
                r.sda_release = rel;
                // only the polling ack decides anything
                if (fin) begin
                    if (ack) begin
                        load_byte(i2cm_pkg::PH_MADDR, word_addr);
                    end else begin
                        bus_phase = i2cm_pkg::PH_PSTOP;
                        half = 0;
                    end
                end
            end
            i2cm_pkg::PH_MADDR: begin
                shift_out(it.sda_in, scl, rel, fin, ack);
                r.scl_level = scl;
                r.sda_release = rel;
                if (fin) begin
                    if (writing) begin
                        load_byte(i2cm_pkg::PH_WDATA, 8'h00);
                    end else begin
                        bus_phase = i2cm_pkg::PH_RESTART;
                        half = 0;
                    end
                end
            end
            i2cm_pkg::PH_DEVR: begin
                shift_out(it.sda_in, scl, rel, fin, ack);
                r.scl_level = scl;
                r.sda_release = rel;
                if (fin) begin
                    bus_phase = i2cm_pkg::PH_RDATA;
                    bit_cnt = '0;
                    half = 0;
                    shreg = '0;
                end
            end
            i2cm_pkg::PH_WDATA: begin
                if (bit_cnt == 0 && half == 0) begin
                    shreg = it.wr_data;
                    r.byte_taken = 1'b1;
                end
                shift_out(it.sda_in, scl, rel, fin, ack);
                r.scl_level = scl;
                r.sda_release = rel;
                if (fin) begin
                    bus_phase = i2cm_pkg::PH_STOP;
                    half = 0;
                end
            end
            i2cm_pkg::PH_RDATA: begin
                last = (bytes_rem <= 1);
                r.scl_level = (half != 0);
                if (bit_cnt < 8) begin
                    r.sda_release = 1'b1;
                    if (half == 0) begin
                        half = 1;
                    end else begin
                        half = 0;
                        shreg = {shreg[6:0], it.sda_in};
                        bit_cnt++;
                        if (bit_cnt == 8) begin
                            r.rd_valid = 1'b1;
                            r.rd_data = shreg;
                            r.rd_last = last;
                        end
                    end
                end else begin
                    // ack every byte but the last one
                    r.sda_release = last;
                    if (half == 0) begin
                        half = 1;
                    end else begin
                        half = 0;
                        bit_cnt = '0;
                        if (last) begin
                            bus_phase = i2cm_pkg::PH_STOP;
                        end else begin
                            bytes_rem--;
                            shreg = '0;
                        end
                    end
                end
            end
            i2cm_pkg::PH_PSTOP, i2cm_pkg::PH_STOP: begin
                r.scl_level = (half != 0);
                r.sda_release = (half == 2);
                if (half != 2) begin
                    half++;
                end else begin
                    half = 1;
                    bit_cnt = '0;
                    if (bus_phase == i2cm_pkg::PH_PSTOP) begin
                        bus_phase = i2cm_pkg::PH_START;
                    end else if (writing && bytes_rem > 1) begin
                        bytes_rem--;
                        word_addr++;
                        bus_phase = i2cm_pkg::PH_START;
                    end else begin
                        if (writing) word_addr++;
                        bytes_rem = '0;
                        r.done_res = 1'b1;
                        bus_phase = i2cm_pkg::PH_IDLE;
                        half = 0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        i2cm_pkg::t_item   acc;
        i2cm_pkg::t_result want;
        i2cm_pkg::t_result got;
        in_fired <= i_rst_n && s_tvalid && o_s_axis_tready;
        out_fired <= i_rst_n && o_m_axis_tvalid && m_tready;
        if (i_rst_n && s_tvalid && o_s_axis_tready) begin
            acc.cmd = s_tuser;
            acc.mem_addr = s_tdata[7:0];
            acc.byte_count = s_tdata[15:8];
            acc.wr_data = s_tdata[23:16];
            acc.sda_in = s_tdata[24];
            eeprom_master_step(acc, want);
            expected_bus.push_back(want);
        end
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            got.scl_level = o_m_axis_tdata[0];
            got.sda_release = o_m_axis_tdata[1];
            got.busy_res = o_m_axis_tdata[2];
            got.rd_valid = o_m_axis_tdata[3];
            got.rd_data = o_m_axis_tdata[11:4];
            got.byte_taken = o_m_axis_tdata[12];
            got.done_res = o_m_axis_tdata[13];
            got.rd_last = o_m_axis_tlast;
            if (expected_bus.size() == 0) begin
                $error("output transfer with no tick waiting for it");
                mismatches++;
            end else begin
                want = expected_bus.pop_front();
                check_field("scl_level", want.scl_level, got.scl_level);
                check_field("sda_release", want.sda_release, got.sda_release);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("rd_valid", want.rd_valid, got.rd_valid);
                check_field("rd_data", want.rd_data, got.rd_data);
                check_field("rd_last", want.rd_last, got.rd_last);
                check_field("byte_taken", want.byte_taken, got.byte_taken);
                check_field("done_res", want.done_res, got.done_res);
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin : feed
        i2cm_pkg::t_item it;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fired) begin
            if (tx_wait != 0) begin
                s_tvalid <= 1'b0;
                tx_wait <= tx_wait - 1;
            end else if (pending_ticks.size() != 0) begin
                it = pending_ticks.pop_front();
                s_tdata <= {{(i2cm_pkg::IN_DATA_W - 25){1'b0}}, it.sda_in, it.wr_data,
                            it.byte_count, it.mem_addr};
                s_tuser <= it.cmd;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
                tx_wait <= tx_calm ? 0 : $urandom_range(0, 12);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : sink
        int unsigned hold;
        if (out_fired) begin
            if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
            hold = rx_calm ? 0 : $urandom_range(0, 12);
            m_tready <= (hold == 0);
            rx_wait <= (hold == 0) ? 0 : hold - 1;
        end else if (rx_wait != 0) begin
            m_tready <= 1'b0;
            rx_wait <= rx_wait - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic i2cm_pkg::t_item rand_item(input logic [1:0] op);
        i2cm_pkg::t_item it;
        it.cmd = op;
        it.mem_addr = 8'($urandom());
        it.byte_count = 8'($urandom());
        it.wr_data = 8'($urandom());
        it.sda_in = 1'($urandom());
        return it;
    endfunction

    task automatic push_request(input logic [1:0] op, input logic [7:0] addr,
                                input logic [7:0] cnt);
        i2cm_pkg::t_item it;
        it = rand_item(op);
        it.mem_addr = addr;
        it.byte_count = cnt;
        pending_ticks.push_back(it);
    endtask

    task automatic wait_quiet();
        while (pending_ticks.size() != 0 || expected_bus.size() != 0 || s_tvalid)
            @(posedge i_clk);
    endtask

    // keep ticking until the predicted sequencer is back in idle
    task automatic run_to_idle(input logic sda_low);
        i2cm_pkg::t_item it;
        wait_quiet();
        while (bus_phase != i2cm_pkg::PH_IDLE) begin
            repeat (16) begin
                it = rand_item(i2cm_pkg::CMD_TICK);
                if (sda_low) it.sda_in = 1'b0;
                pending_ticks.push_back(it);
            end
            wait_quiet();
        end
    endtask

    task automatic load_dev_addr(input logic [6:0] v);
        run_to_idle(1'b0);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        dev_addr = v;
    endtask

    // requests followed by roughly enough ticks to finish them, some cut short
    task automatic random_traffic(input int unsigned target);
        i2cm_pkg::t_item it;
        int unsigned made;
        int unsigned est;
        int unsigned cnt;
        int unsigned pick;
        logic [1:0]  op;
        made = 0;
        while (made < target) begin
            op = ($urandom_range(0, 1) == 0) ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
            pick = $urandom_range(0, 29);
            if (pick == 0) cnt = $urandom_range(0, 8);
            else if (pick < 3) cnt = 0;
            else cnt = $urandom_range(1, 4);
            push_request(op, 8'($urandom()), 8'(cnt));
            if (op == i2cm_pkg::CMD_WRITE) est = cnt * 81;
            else est = 84 + 18 * ((cnt == 0) ? 1 : cnt);
            est = est + $urandom_range(0, 30);
            if ($urandom_range(0, 7) == 0) est = $urandom_range(0, est);
            repeat (est) begin
                it = rand_item(($urandom_range(0, 15) == 0) ? 2'($urandom())
                                                            : i2cm_pkg::CMD_TICK);
                pending_ticks.push_back(it);
            end
            made = made + est + 1;
        end
        run_to_idle(1'b0);
    endtask

    initial begin : stimulus
        logic [6:0] dev_plan [4];
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // plain ticks while idle
        repeat (3) pending_ticks.push_back(rand_item(i2cm_pkg::CMD_TICK));
        // single byte read with the line held low: immediate ack, all-zero data
        push_request(i2cm_pkg::CMD_READ, 8'h00, 8'd1);
        run_to_idle(1'b1);
        // read of zero bytes reads one
        push_request(i2cm_pkg::CMD_READ, 8'hFF, 8'd0);
        run_to_idle(1'b0);
        // write across the top of the address space
        push_request(i2cm_pkg::CMD_WRITE, 8'hFF, 8'd3);
        run_to_idle(1'b0);
        // write of zero bytes and the unused command leave the block idle
        push_request(i2cm_pkg::CMD_WRITE, 8'h10, 8'd0);
        pending_ticks.push_back(rand_item(CMD_NONE));
        run_to_idle(1'b0);
        // commands arriving while busy are dropped
        push_request(i2cm_pkg::CMD_READ, 8'h5A, 8'd2);
        pending_ticks.push_back(rand_item(i2cm_pkg::CMD_WRITE));
        pending_ticks.push_back(rand_item(i2cm_pkg::CMD_READ));
        pending_ticks.push_back(rand_item(CMD_NONE));
        pending_ticks.push_back(rand_item(i2cm_pkg::CMD_WRITE));
        pending_ticks.push_back(rand_item(i2cm_pkg::CMD_READ));
        run_to_idle(1'b0);
        // a longer read and a multi-byte write
        push_request(i2cm_pkg::CMD_READ, 8'hA5, 8'd6);
        run_to_idle(1'b0);
        push_request(i2cm_pkg::CMD_WRITE, 8'h00, 8'd2);
        run_to_idle(1'b0);

        dev_plan[0] = 7'h7F;
        dev_plan[1] = 7'h00;
        dev_plan[2] = 7'($urandom());
        dev_plan[3] = 7'($urandom());
        foreach (dev_plan[i]) begin
            load_dev_addr(dev_plan[i]);
            random_traffic(150);
        end

        wait_quiet();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_bus.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
